>>> rtl/cht_pkg.sv
// shared constants, payload types and controller/datapath interface types
`timescale 1ns / 1ps
package cht_pkg;

   localparam int MaxBuckets   = 16;
   localparam int PoolEntries  = 64;
   localparam int BucketW      = $clog2(MaxBuckets);
   localparam int EntryW       = $clog2(PoolEntries);
   localparam int LinkW        = EntryW + 1;
   localparam int CountW       = $clog2(PoolEntries + 1);
   localparam int BcountW      = 5;
   localparam int KeyW         = 31;
   localparam int ValueW       = 64;
   localparam int KeyBitW      = $clog2(KeyW);
   localparam logic [BcountW-1:0] ResetBuckets = BcountW'(13);

   typedef enum logic [1:0] {
      REQ_LOOKUP = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_OTHER  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } rsp_status_type;

   typedef struct packed {
      req_kind_type      req_type;
      logic [KeyW-1:0]   key;
      logic [ValueW-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic              found;
      logic [ValueW-1:0] result_value;
      rsp_status_type    status;
      logic [CountW-1:0] entry_count;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic head_load;
      logic fetch;
      logic advance;
      logic mark_hit;
      logic update;
      logic ins_a;
      logic ins_b;
      logic remove;
      logic finish;
   } cmd_type;

   typedef struct packed {
      req_kind_type      kind;
      logic              div_last;
      logic              cur_none;
      logic              next_none;
      logic              key_hit;
      logic              walk_limit;
      logic              pool_empty;
      logic              rsp_free;
      logic [CountW-1:0] free_count;
      logic [CountW-1:0] held_count;
   } stat_type;

endpackage

>>> rtl/cht_ctrl.sv
// request sequencer: modulo, chain walk and table update steps
`timescale 1ns / 1ps
module cht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cht_pkg::stat_type stat,
   output cht_pkg::cmd_type  cmd
);
   import cht_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_DIV   = 11'b000_0000_0010,
      S_HEAD  = 11'b000_0000_0100,
      S_FETCH = 11'b000_0000_1000,
      S_CMP   = 11'b000_0001_0000,
      S_UPD   = 11'b000_0010_0000,
      S_REM   = 11'b000_0100_0000,
      S_INS_A = 11'b000_1000_0000,
      S_INS_B = 11'b001_0000_0000,
      S_FIN   = 11'b010_0000_0000,
      S_SPARE = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   state_type miss_state;

   assign miss_state = (stat.kind == REQ_INSERT && !stat.pool_empty) ? S_INS_A : S_FIN;
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_HEAD;
         end
         S_HEAD: begin
            cmd.head_load = 1'b1;
            state_in      = S_FETCH;
         end
         S_FETCH: begin
            if (stat.cur_none) begin
               state_in = miss_state;
            end else begin
               cmd.fetch = 1'b1;
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.key_hit) begin
               cmd.mark_hit = 1'b1;
               case (stat.kind)
                  REQ_INSERT: state_in = S_UPD;
                  REQ_REMOVE: state_in = S_REM;
                  default:    state_in = S_FIN;
               endcase
            end else if (stat.next_none || stat.walk_limit) begin
               state_in = miss_state;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_FETCH;
            end
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_FIN;
         end
         S_REM: begin
            cmd.remove = 1'b1;
            state_in   = S_FIN;
         end
         S_INS_A: begin
            cmd.ins_a = 1'b1;
            state_in  = S_INS_B;
         end
         S_INS_B: begin
            cmd.ins_b = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> rtl/cht_datapath.sv
// divider, bucket heads, entry pool memories, free stack and result register
`timescale 1ns / 1ps
module cht_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  cht_pkg::cmd_type           cmd,
   output cht_pkg::stat_type          stat,
   input  logic [cht_pkg::BcountW-1:0] bucket_count,
   input  cht_pkg::req_payload_type   req_payload,
   output cht_pkg::rsp_payload_type   rsp_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready
);
   import cht_pkg::*;

   localparam logic [LinkW-1:0] NoLink = {1'b1, {EntryW{1'b0}}};

   req_kind_type        kind_ff;
   logic [KeyW-1:0]     key_ff;
   logic [ValueW-1:0]   value_ff;
   logic [BcountW-1:0]  rem_ff, div_ff, rem_shift;
   logic [KeyBitW-1:0]  bit_ff;
   logic [BcountW-1:0]  active;
   logic [BucketW-1:0]  bucket;
   logic [LinkW-1:0]    cur_ff, old_head_ff, head_link;
   logic [CountW-1:0]   steps_ff, free_ff, held_ff, low_ff;
   logic                hit_ff;
   logic                full_ff;
   logic [EntryW-1:0]   new_ff, pop_pos, pop_entry;

   logic [EntryW-1:0]   head_ff     [MaxBuckets];
   logic [MaxBuckets-1:0] head_vld_ff;

   logic [KeyW-1:0]     key_mem   [PoolEntries];
   logic [ValueW-1:0]   value_mem [PoolEntries];
   logic [LinkW-1:0]    next_mem  [PoolEntries];
   logic [LinkW-1:0]    prev_mem  [PoolEntries];
   logic [EntryW-1:0]   stack_mem [PoolEntries];
   logic [KeyW-1:0]     key_rd;
   logic [ValueW-1:0]   value_rd;
   logic [LinkW-1:0]    next_rd, prev_rd;
   logic [EntryW-1:0]   stack_rd;

   rsp_payload_type     rsp_ff;
   logic                rsp_valid_ff;
   rsp_status_type      status_w;

   // zero acts as one bucket, anything above the maximum as the maximum
   always_comb begin
      if (bucket_count == '0) active = BcountW'(1);
      else if (bucket_count > BcountW'(MaxBuckets)) active = BcountW'(MaxBuckets);
      else active = bucket_count;
   end

   assign rem_shift = {rem_ff[BcountW-2:0], key_ff[bit_ff]};
   assign bucket    = rem_ff[BucketW-1:0];
   assign head_link = head_vld_ff[bucket] ? {1'b0, head_ff[bucket]} : NoLink;
   assign pop_pos   = EntryW'(free_ff - CountW'(1));
   // stack slots below the low mark were never pushed, so their entry is reckoned in reset order
   assign pop_entry = (free_ff == low_ff) ? EntryW'(PoolEntries - 1) - pop_pos : stack_rd;

   // request capture and restoring remainder, one key bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_payload.req_type;
         key_ff   <= req_payload.key;
         value_ff <= req_payload.value;
         rem_ff   <= '0;
         bit_ff   <= KeyBitW'(KeyW - 1);
         div_ff   <= active;
      end else if (cmd.div_step) begin
         rem_ff <= (rem_shift >= div_ff) ? rem_shift - div_ff : rem_shift;
         bit_ff <= bit_ff - KeyBitW'(1);
      end
   end

   // chain walk pointer
   always_ff @(posedge clock) begin
      if (cmd.head_load) begin
         cur_ff      <= head_link;
         old_head_ff <= head_link;
         steps_ff    <= '0;
         stack_rd    <= stack_mem[pop_pos];
         full_ff     <= (free_ff == '0);
      end else if (cmd.advance) begin
         cur_ff   <= next_rd;
         steps_ff <= steps_ff + CountW'(1);
      end
      if (cmd.ins_a) new_ff <= pop_entry;
   end

   always_ff @(posedge clock) begin
      if (reset)            hit_ff <= 1'b0;
      else if (cmd.capture) hit_ff <= 1'b0;
      else if (cmd.mark_hit) hit_ff <= 1'b1;
   end

   // pool memories with registered reads
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         key_rd   <= key_mem[cur_ff[EntryW-1:0]];
         value_rd <= value_mem[cur_ff[EntryW-1:0]];
         next_rd  <= next_mem[cur_ff[EntryW-1:0]];
         prev_rd  <= prev_mem[cur_ff[EntryW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_a) key_mem[pop_entry] <= key_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_a)       value_mem[pop_entry] <= value_ff;
      else if (cmd.update) value_mem[cur_ff[EntryW-1:0]] <= value_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_a) next_mem[pop_entry] <= old_head_ff;
      else if (cmd.remove && !prev_rd[EntryW]) next_mem[prev_rd[EntryW-1:0]] <= next_rd;
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_a) prev_mem[pop_entry] <= NoLink;
      else if (cmd.ins_b && !old_head_ff[EntryW])
         prev_mem[old_head_ff[EntryW-1:0]] <= {1'b0, new_ff};
      else if (cmd.remove && !next_rd[EntryW]) prev_mem[next_rd[EntryW-1:0]] <= prev_rd;
   end

   always_ff @(posedge clock) begin
      if (cmd.remove) stack_mem[free_ff[EntryW-1:0]] <= cur_ff[EntryW-1:0];
   end

   // bucket heads
   always_ff @(posedge clock) begin
      if (cmd.ins_a) head_ff[bucket] <= pop_entry;
      else if (cmd.remove && prev_rd[EntryW]) head_ff[bucket] <= next_rd[EntryW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) head_vld_ff <= '0;
      else if (cmd.ins_a) head_vld_ff[bucket] <= 1'b1;
      else if (cmd.remove && prev_rd[EntryW]) head_vld_ff[bucket] <= !next_rd[EntryW];
   end

   // pool counters
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= CountW'(PoolEntries);
         held_ff <= '0;
         low_ff  <= CountW'(PoolEntries);
      end else if (cmd.ins_a) begin
         free_ff <= free_ff - CountW'(1);
         held_ff <= held_ff + CountW'(1);
         if (free_ff == low_ff) low_ff <= free_ff - CountW'(1);
      end else if (cmd.remove) begin
         free_ff <= free_ff + CountW'(1);
         held_ff <= held_ff - CountW'(1);
      end
   end

   // result register
   always_comb begin
      if (hit_ff) status_w = ST_DONE;
      else if (kind_ff != REQ_INSERT) status_w = ST_MISS;
      else if (full_ff) status_w = ST_FULL;
      else status_w = ST_DONE;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.found        <= hit_ff;
         rsp_ff.result_value <= hit_ff ? value_rd : '0;
         rsp_ff.status       <= status_w;
         rsp_ff.entry_count  <= held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp_ready)  rsp_valid_ff <= 1'b0;
   end

   assign rsp_payload = rsp_ff;
   assign rsp_valid   = rsp_valid_ff;

   assign stat.kind       = kind_ff;
   assign stat.div_last   = (bit_ff == '0);
   assign stat.cur_none   = cur_ff[EntryW];
   assign stat.next_none  = next_rd[EntryW];
   assign stat.key_hit    = (key_rd == key_ff);
   assign stat.walk_limit = (steps_ff == CountW'(PoolEntries - 1));
   assign stat.pool_empty = (free_ff == '0);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign stat.free_count = free_ff;
   assign stat.held_count = held_ff;

endmodule

>>> rtl/chained_hash_table.sv
// top level: register port, sequencer and datapath of the chained hash table
`timescale 1ns / 1ps
// Key-value table with separate chaining over a pool of 64 entries and up to 16
// buckets (bucket = key mod bucket_count, register at address 0, reset 13). One
// request is taken at a time and gives one result transfer. The remainder unit
// takes one key bit per cycle, and each chain step is a read of the entry
// memory and a key compare. The result register frees the request side as soon
// as the result is loaded; a result still waiting for its transfer holds the
// next one, and with it the request side, until it is taken.
module chained_hash_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cht_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cht_pkg::rsp_payload_type  rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [1:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import cht_pkg::*;

   logic [BcountW-1:0] bucket_count_ff;
   cmd_type            cmd;
   stat_type           stat;

   // single register, so the address carries only the byte offset
   always_ff @(posedge clock) begin
      if (reset) bucket_count_ff <= ResetBuckets;
      else if (psel && penable && pwrite && paddr == 2'd0)
         bucket_count_ff <= pwdata[BcountW-1:0];
   end

   assign prdata = {{(32 - BcountW){1'b0}}, bucket_count_ff};
   assign pready = 1'b1;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cht_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .bucket_count (bucket_count_ff),
      .req_payload  (req_payload),
      .rsp_payload  (rsp_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready)
   );

   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      (stat.free_count + stat.held_count) == CountW'(PoolEntries))
      else $error("free and held entries do not add up to the pool size");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_FULL
         |-> rsp_payload.entry_count == CountW'(PoolEntries))
      else $error("insert refused while the pool has free entries");

   a_hit_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.found |-> rsp_payload.status == ST_DONE)
      else $error("hit reported with a failure status");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in progress");

endmodule
